### hw/rtl/button_gesture_classifier_top_assert.svh
// assertion macros for the gesture classifier
`ifndef BUTTON_GESTURE_CLASSIFIER_TOP_ASSERT_SVH
`define BUTTON_GESTURE_CLASSIFIER_TOP_ASSERT_SVH

`ifndef SYNTHESIS

// same-cycle implication, held off during reset
`define BGC_ASSERT_IMPLY(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("assertion failed: same-cycle implication");

// next-cycle implication, held off during reset
`define BGC_ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("assertion failed: next-cycle implication");

`else

`define BGC_ASSERT_IMPLY(label, clk, rst, ante, cons)
`define BGC_ASSERT_NEXT(label, clk, rst, ante, cons)

`endif

`endif

### hw/rtl/bgc_pkg.sv
package bgc_pkg;

  localparam int TIMER_W = 8;
  localparam int STATE_W = 3;
  localparam int GEST_W  = 3;
  localparam int CFG_IDX_W = 2;

  // gesture machine states
  localparam logic [STATE_W-1:0] ST_IDLE      = 3'd0;
  localparam logic [STATE_W-1:0] ST_CLICK1    = 3'd1;
  localparam logic [STATE_W-1:0] ST_PRE2      = 3'd2;
  localparam logic [STATE_W-1:0] ST_CLICK2    = 3'd3;
  localparam logic [STATE_W-1:0] ST_HOLD_WAIT = 3'd4;
  localparam logic [STATE_W-1:0] ST_CNH_WAIT  = 3'd5;
  localparam logic [STATE_W-1:0] ST_REL_WAIT  = 3'd6;

  // gesture codes on the result word
  localparam logic [GEST_W-1:0] G_NONE  = 3'd0;
  localparam logic [GEST_W-1:0] G_CLICK = 3'd1;
  localparam logic [GEST_W-1:0] G_DBL   = 3'd2;
  localparam logic [GEST_W-1:0] G_HOLD  = 3'd3;
  localparam logic [GEST_W-1:0] G_CNH   = 3'd4;
  localparam logic [GEST_W-1:0] G_LONG  = 3'd5;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_CLICK_WINDOW = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_HOLD         = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_LONG_HOLD    = 2'd2;

  // configuration reset values
  localparam logic [TIMER_W-1:0] CLICK_WINDOW_RST = 8'd15;
  localparam logic [TIMER_W-1:0] HOLD_RST         = 8'd15;
  localparam logic [TIMER_W-1:0] LONG_HOLD_RST    = 8'd109;

  // machine events
  typedef enum logic [1:0] {
    EV_NONE,
    EV_PRESS,
    EV_RELEASE,
    EV_TIMEOUT
  } event_t;

endpackage

### hw/rtl/button_gesture_classifier_top.sv
// channel  | direction | handshake          | payload
// in       | to block  | in_valid/in_stall  | button_level
// out      | from block| out_valid/out_stall| gesture
// cfg      | to block  | cfg_valid/cfg_ready| cfg_index, cfg_data
//
// one word per clock sustained while the result register is free; a word taken
// passes from the input register through the gesture logic into the result register
// reset clears the machine, timer, level, valid flags and loads default timer lengths
// out_stall holds the result; the input register still takes a word while the
// result register is free, in_stall rises only when both stages are full
// cfg_ready is always high; writes to index 3 are dropped
`include "button_gesture_classifier_top_assert.svh"

module button_gesture_classifier_top (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              in_valid,
  output logic                              in_stall,
  input  logic                              button_level,
  output logic                              out_valid,
  input  logic                              out_stall,
  output logic [bgc_pkg::GEST_W-1:0]        gesture,
  input  logic                              cfg_valid,
  output logic                              cfg_ready,
  input  logic [bgc_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [bgc_pkg::TIMER_W-1:0]       cfg_data
);

  // configuration registers
  logic [bgc_pkg::TIMER_W-1:0] click_window_ticks;
  logic [bgc_pkg::TIMER_W-1:0] hold_ticks;
  logic [bgc_pkg::TIMER_W-1:0] long_hold_ticks;

  // machine state
  logic [bgc_pkg::STATE_W-1:0] gesture_state, gesture_state_next;
  logic [bgc_pkg::TIMER_W-1:0] gesture_timer, gesture_timer_next;
  logic                        last_level, last_level_next;

  // pipeline registers
  logic                        in_reg_valid;
  logic                        in_reg_level;
  logic [bgc_pkg::GEST_W-1:0]  res_gesture;
  logic [bgc_pkg::GEST_W-1:0]  gesture_next;

  logic                  res_free;
  logic                  process;
  logic                  timeout;
  logic [bgc_pkg::TIMER_W-1:0] timer_dec;
  bgc_pkg::event_t       ev;

  // terms watched by the checks
  logic                  idle_now;
  logic                  hold_reported;

  assign cfg_ready = 1'b1;
  assign res_free  = !out_valid || !out_stall;
  assign process   = in_reg_valid && res_free;
  assign in_stall  = in_reg_valid && !res_free;
  assign gesture   = res_gesture;

  // config writes
  always_ff @(posedge clk) begin
    if (rst) begin
      click_window_ticks <= bgc_pkg::CLICK_WINDOW_RST;
      hold_ticks         <= bgc_pkg::HOLD_RST;
      long_hold_ticks    <= bgc_pkg::LONG_HOLD_RST;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        bgc_pkg::CFG_CLICK_WINDOW: click_window_ticks <= cfg_data;
        bgc_pkg::CFG_HOLD:         hold_ticks         <= cfg_data;
        bgc_pkg::CFG_LONG_HOLD:    long_hold_ticks    <= cfg_data;
        default: ;
      endcase
    end
  end

  // timer service and event decode
  always_comb begin
    timer_dec = (gesture_timer != '0) ? gesture_timer - 1'b1 : gesture_timer;
    timeout   = (gesture_timer == {{(bgc_pkg::TIMER_W-1){1'b0}}, 1'b1});
    last_level_next = last_level;
    if (timeout) begin
      ev = bgc_pkg::EV_TIMEOUT;
    end else if (in_reg_level != last_level) begin
      ev = in_reg_level ? bgc_pkg::EV_PRESS : bgc_pkg::EV_RELEASE;
      last_level_next = in_reg_level;
    end else begin
      ev = bgc_pkg::EV_NONE;
    end
  end

  // gesture machine
  always_comb begin
    gesture_state_next = gesture_state;
    gesture_timer_next = timer_dec;
    gesture_next       = bgc_pkg::G_NONE;
    unique case (gesture_state)
      bgc_pkg::ST_CLICK1: begin
        if (ev == bgc_pkg::EV_RELEASE) begin
          gesture_next       = bgc_pkg::G_CLICK;
          gesture_state_next = bgc_pkg::ST_PRE2;
        end else if (ev == bgc_pkg::EV_TIMEOUT) begin
          gesture_timer_next = hold_ticks;
          gesture_state_next = bgc_pkg::ST_HOLD_WAIT;
        end
      end
      bgc_pkg::ST_PRE2: begin
        if (ev == bgc_pkg::EV_PRESS) begin
          gesture_state_next = bgc_pkg::ST_CLICK2;
        end else if (ev == bgc_pkg::EV_TIMEOUT) begin
          gesture_state_next = bgc_pkg::ST_IDLE;
        end
      end
      bgc_pkg::ST_CLICK2: begin
        if (ev == bgc_pkg::EV_RELEASE) begin
          gesture_next       = bgc_pkg::G_DBL;
          gesture_timer_next = '0;
          gesture_state_next = bgc_pkg::ST_IDLE;
        end else if (ev == bgc_pkg::EV_TIMEOUT) begin
          gesture_timer_next = hold_ticks;
          gesture_state_next = bgc_pkg::ST_CNH_WAIT;
        end
      end
      bgc_pkg::ST_HOLD_WAIT, bgc_pkg::ST_CNH_WAIT: begin
        if (ev == bgc_pkg::EV_RELEASE) begin
          gesture_timer_next = '0;
          gesture_state_next = bgc_pkg::ST_IDLE;
        end else if (ev == bgc_pkg::EV_TIMEOUT) begin
          gesture_next = (gesture_state == bgc_pkg::ST_HOLD_WAIT) ?
                         bgc_pkg::G_HOLD : bgc_pkg::G_CNH;
          gesture_timer_next = long_hold_ticks;
          gesture_state_next = bgc_pkg::ST_REL_WAIT;
        end
      end
      bgc_pkg::ST_REL_WAIT: begin
        if (ev == bgc_pkg::EV_RELEASE) begin
          gesture_timer_next = '0;
          gesture_state_next = bgc_pkg::ST_IDLE;
        end else if (ev == bgc_pkg::EV_TIMEOUT) begin
          gesture_next       = bgc_pkg::G_LONG;
          gesture_state_next = bgc_pkg::ST_IDLE;
        end
      end
      default: begin
        // idle and the unused code
        if (ev == bgc_pkg::EV_PRESS) begin
          gesture_timer_next = click_window_ticks;
          gesture_state_next = bgc_pkg::ST_CLICK1;
        end
      end
    endcase
  end

  // input register
  always_ff @(posedge clk) begin
    if (rst) begin
      in_reg_valid <= 1'b0;
    end else if (!in_stall) begin
      in_reg_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (!in_stall && in_valid) begin
      in_reg_level <= button_level;
    end
  end

  // state update, one word per process cycle
  always_ff @(posedge clk) begin
    if (rst) begin
      gesture_state <= bgc_pkg::ST_IDLE;
      gesture_timer <= '0;
      last_level    <= 1'b0;
    end else if (process) begin
      gesture_state <= gesture_state_next;
      gesture_timer <= gesture_timer_next;
      last_level    <= last_level_next;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (res_free) begin
      out_valid <= in_reg_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (process) begin
      res_gesture <= gesture_next;
    end
  end

  // checks
  assign idle_now      = (gesture_state == bgc_pkg::ST_IDLE);
  assign hold_reported = process &&
                         (gesture_next == bgc_pkg::G_HOLD || gesture_next == bgc_pkg::G_CNH);

  `BGC_ASSERT_IMPLY(a_idle_timer_clear, clk, rst, idle_now, gesture_timer == '0)
  `BGC_ASSERT_NEXT(a_hold_to_rel_wait, clk, rst, hold_reported, gesture_state == bgc_pkg::ST_REL_WAIT)
  `BGC_ASSERT_IMPLY(a_stall_means_full, clk, rst, in_stall, in_reg_valid && out_valid)

endmodule
